FILE: design/gcns_pkg.sv
// Package: constants and types for the group-call notification scheduler.
package gcns_pkg;
   localparam int MaxEntries = 8;
   localparam int IdxW       = $clog2(MaxEntries);
   localparam int CntW       = $clog2(MaxEntries + 1);
   localparam int RefW       = 40;
   localparam int DescW      = 24;
   localparam int BlockBytes = 23;
   localparam int BitW       = 8 * (BlockBytes - 3);

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_DEL = 2'd1;
   localparam logic [1:0] FUNC_RST = 2'd2;
   localparam logic [1:0] FUNC_GEN = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_NOTFND = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [RefW-1:0]  gref;
      logic [DescW-1:0] desc;
      logic [1:0]       dlen;
   } entry_type;
endpackage

FILE: design/group_call_notification_scheduler.sv
// Top level: group-call notification scheduler, table in a synchronous memory.
//
// The table of up to eight notifications lives in one synchronous memory
// (one write, one registered read per cycle) addressed through a circular
// order: a head pointer plus an offset gives the physical slot, so a generate
// rotates the front entry to the back by copying it into the slot after the
// last entry and moving the head on by one. Each item is handled one at a
// time. An add or delete reads the table entry by entry to search for the
// reference; a delete then closes the gap by moving each following entry one
// place forward. An add writes the new entry in front of the head. A generate
// reads the front entry, builds the block, then sends its 23 bytes one
// transfer per cycle while the receiver does not stall.
// The response register parts the sides: a result waits there while stalled.
module group_call_notification_scheduler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_func,
   input  logic [gcns_pkg::RefW-1:0] req_group_ref,
   input  logic [gcns_pkg::DescW-1:0] req_chan_desc,
   input  logic [1:0]                req_chan_desc_len,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [7:0]                rsp_block_byte,
   output logic                      rsp_last
);
   import gcns_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRCH  = 3'd1;  // search read pipeline
   localparam logic [2:0] S_SHRD  = 3'd2;  // delete: read next entry
   localparam logic [2:0] S_SHWR  = 3'd3;  // delete: write it one place on
   localparam logic [2:0] S_GRD   = 3'd4;  // generate: wait read data
   localparam logic [2:0] S_GOUT  = 3'd5;  // generate: stream bytes
   localparam logic [2:0] S_RESP  = 3'd6;  // single response waiting

   entry_type mem [MaxEntries];
   entry_type rd_data_ff;
   logic [IdxW-1:0] rd_addr;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   entry_type       wr_data;

   logic [2:0]      state_ff, state_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [CntW-1:0] total_ff, total_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [1:0]      listn_ff, listn_in;
   logic            tog_ff, tog_in;
   logic [CntW-1:0] cnt_ff, cnt_in;     // search issue / shift offset
   logic            rdv_ff, rdv_in;     // a search read is in flight
   logic [CntW-1:0] rdo_ff, rdo_in;     // offset of that read
   logic [1:0]      func_ff, func_in;
   logic [RefW-1:0] ref_ff, ref_in;
   logic [DescW-1:0] desc_ff, desc_in;
   logic [1:0]      dlen_ff, dlen_in;
   logic            flag_ff, flag_in;   // list-number flag of this generate
   logic [1:0]      sts_ff, sts_in;     // status of a table operation
   logic [BitW-1:0] bits_ff, bits_in;
   logic [4:0]      bidx_ff, bidx_in;
   logic            ov_ff, ov_in;
   logic [1:0]      ost_ff, ost_in;
   logic [7:0]      obyte_ff, obyte_in;
   logic            olast_ff, olast_in;

   logic            out_free;
   logic [1:0]      sat_len;
   logic [BitW+63:0] gen_bits;
   logic [6:0]      gen_len;

   assign rsp_valid      = ov_ff;
   assign rsp_status     = ost_ff;
   assign rsp_block_byte = obyte_ff;
   assign rsp_last       = olast_ff;
   assign out_free       = !ov_ff || !rsp_stall;
   assign req_stall      = (state_ff != S_IDLE);
   assign sat_len        = req_chan_desc_len;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // assemble the generate bit string, MSB aligned, then fill with 0x2B
   always_comb begin
      gen_bits = '0;
      gen_len  = '0;
      if (flag_ff) begin
         gen_bits[BitW+63 -: 3] = {1'b1, listn_ff};
         gen_len = 7'd3;
      end else begin
         gen_len = 7'd1;
      end
      if (total_ff != '0) begin
         gen_bits[BitW+63 - 32'(gen_len) -: 37] = {1'b1, rd_data_ff.gref[RefW-1:4]};
         gen_len = gen_len + 7'd37;
         case (rd_data_ff.dlen)
            2'd1: begin
               gen_bits[BitW+63 - 32'(gen_len) -: 10] =
                  {1'b1, rd_data_ff.desc[23:16], 1'b0};
               gen_len = gen_len + 7'd10;
            end
            2'd2: begin
               gen_bits[BitW+63 - 32'(gen_len) -: 18] =
                  {1'b1, rd_data_ff.desc[23:8], 1'b0};
               gen_len = gen_len + 7'd18;
            end
            2'd3: begin
               gen_bits[BitW+63 - 32'(gen_len) -: 26] =
                  {1'b1, rd_data_ff.desc, 1'b0};
               gen_len = gen_len + 7'd26;
            end
            default: gen_len = gen_len + 7'd1;
         endcase
      end
      gen_len = gen_len + 7'd1;  // final zero bit (already zero)
   end

   always_comb begin
      logic [BitW-1:0] fill;
      logic [BitW-1:0] mask;
      fill = {(BlockBytes - 3){8'h2B}};
      mask = ~({BitW{1'b1}} >> gen_len);
      state_in = state_ff;
      head_in  = head_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      listn_in = listn_ff;
      tog_in   = tog_ff;
      cnt_in   = cnt_ff;
      rdv_in   = 1'b0;
      rdo_in   = rdo_ff;
      func_in  = func_ff;
      ref_in   = ref_ff;
      desc_in  = desc_ff;
      dlen_in  = dlen_ff;
      flag_in  = flag_ff;
      sts_in   = sts_ff;
      bits_in  = bits_ff;
      bidx_in  = bidx_ff;
      ov_in    = ov_ff && rsp_stall;
      ost_in   = ost_ff;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      rd_addr  = head_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      wr_data  = '{gref: ref_ff, desc: desc_ff, dlen: dlen_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               ref_in  = req_group_ref;
               desc_in = req_chan_desc;
               dlen_in = sat_len;
               cnt_in  = '0;
               unique case (req_func)
                  FUNC_RST: begin
                     total_in = '0;
                     pos_in   = '0;
                     tog_in   = !tog_ff;
                     sts_in   = ST_OK;
                     state_in = S_RESP;
                  end
                  FUNC_GEN: begin
                     rd_addr  = head_ff;
                     flag_in  = (CntW'(pos_ff + 1'b1) >= total_ff) || (total_ff == '0);
                     state_in = S_GRD;
                  end
                  default: state_in = S_SRCH;
               endcase
            end
         end
         S_SRCH: begin
            // issue one read a cycle, check the one returning
            if (cnt_ff < total_ff) begin
               rd_addr = IdxW'(head_ff + IdxW'(cnt_ff));
               rdv_in  = 1'b1;
               rdo_in  = cnt_ff;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (rdv_ff && rd_data_ff.gref == ref_ff) begin
               rdv_in = 1'b0;
               if (func_ff == FUNC_ADD) begin
                  sts_in   = ST_DUP;
                  state_in = S_RESP;
               end else begin
                  cnt_in   = rdo_ff;
                  state_in = S_SHRD;
               end
            end else if (!rdv_ff && cnt_ff >= total_ff) begin
               if (func_ff == FUNC_DEL) begin
                  sts_in   = ST_NOTFND;
                  state_in = S_RESP;
               end else if (total_ff >= CntW'(MaxEntries)) begin
                  sts_in   = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_ff - 1'b1;
                  head_in  = head_ff - 1'b1;
                  total_in = total_ff + 1'b1;
                  pos_in   = '0;
                  listn_in = listn_ff + 1'b1;
                  sts_in   = ST_OK;
                  state_in = S_RESP;
               end
            end
         end
         S_SHRD: begin
            if (CntW'(cnt_ff + 1'b1) >= total_ff) begin
               total_in = total_ff - 1'b1;
               pos_in   = '0;
               tog_in   = !tog_ff;
               sts_in   = ST_OK;
               state_in = S_RESP;
            end else begin
               rd_addr  = IdxW'(head_ff + IdxW'(cnt_ff) + 1'b1);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en    = 1'b1;
            wr_addr  = IdxW'(head_ff + IdxW'(cnt_ff));
            wr_data  = rd_data_ff;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_SHRD;
         end
         S_GRD: begin
            bits_in = (fill & ~mask) | (gen_bits[BitW+63 -: BitW] & mask);
            pos_in  = (CntW'(pos_ff + 1'b1) >= total_ff) ? '0 : CntW'(pos_ff + 1'b1);
            // front entry copied behind the last one, then the head moves on
            if (total_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = IdxW'(head_ff + IdxW'(total_ff));
               wr_data = rd_data_ff;
               head_in = head_ff + 1'b1;
            end
            bidx_in  = '0;
            state_in = S_GOUT;
         end
         S_GOUT: begin
            if (out_free) begin
               ov_in  = 1'b1;
               ost_in = ST_OK;
               olast_in = (bidx_ff == 5'(BlockBytes - 1));
               unique case (bidx_ff)
                  5'd0:    obyte_in = 8'h09;
                  5'd1:    obyte_in = 8'h06;
                  5'd2:    obyte_in = 8'h20;
                  default: begin
                     obyte_in = bits_ff[BitW-1 -: 8];
                     bits_in  = bits_ff << 8;
                  end
               endcase
               bidx_in = bidx_ff + 1'b1;
               if (bidx_ff == 5'(BlockBytes - 1)) state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (out_free) begin
               ov_in    = 1'b1;
               ost_in   = sts_ff;
               obyte_in = 8'h00;
               olast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         total_ff <= '0;
         pos_ff   <= '0;
         listn_ff <= '0;
         tog_ff   <= 1'b0;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         total_ff <= total_in;
         pos_ff   <= pos_in;
         listn_ff <= listn_in;
         tog_ff   <= tog_in;
         rdv_ff   <= rdv_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rdo_ff   <= rdo_in;
      func_ff  <= func_in;
      ref_ff   <= ref_in;
      desc_ff  <= desc_in;
      dlen_ff  <= dlen_in;
      flag_ff  <= flag_in;
      sts_ff   <= sts_in;
      bits_ff  <= bits_in;
      bidx_ff  <= bidx_in;
      ost_ff   <= ost_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end
endmodule

FILE: tb/sv/gcns_checker.sv
// Checker: watches both channels, predicts the scheduler's results and compares them.
module gcns_checker
   import gcns_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [RefW-1:0]      req_group_ref,
   input  logic [DescW-1:0]     req_chan_desc,
   input  logic [1:0]           req_chan_desc_len,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_status,
   input  logic [7:0]           rsp_block_byte,
   input  logic                 rsp_last,
   output int                   fail_count,
   output int                   pending_count,
   output int                   rsp_seen
);
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] byte_val;
      logic       last;
   } sched_result;

   sched_result     awaited_q[$];
   logic [RefW-1:0]  tbl_ref [MaxEntries];
   logic [DescW-1:0] tbl_desc[MaxEntries];
   logic [1:0]       tbl_len [MaxEntries];
   int               tbl_total, notify_pos;
   logic [1:0]       list_num;
   logic [7:0]       blk[BlockBytes];
   int               bit_idx;

   assign pending_count = awaited_q.size();

   function automatic void put_bit(logic v);
      int b;
      b = 3 + bit_idx / 8;
      if (b < BlockBytes) blk[b][7 - bit_idx % 8] = v;
      bit_idx++;
   endfunction

   function automatic int find_entry(logic [RefW-1:0] r);
      for (int i = 0; i < tbl_total; i++)
         if (tbl_ref[i] == r) return i;
      return -1;
   endfunction

   task automatic predict_item(logic [1:0] f, logic [RefW-1:0] r,
                               logic [DescW-1:0] d, logic [1:0] l);
      int          idx;
      logic [1:0]  st;
      sched_result res;
      logic [RefW-1:0]  fr;
      logic [DescW-1:0] fd;
      logic [1:0]       fl;
      st = ST_OK;
      if (f == FUNC_GEN) begin
         blk[0] = 8'h09; blk[1] = 8'h06; blk[2] = 8'h20;
         for (int i = 3; i < BlockBytes; i++) blk[i] = 8'h2B;
         bit_idx = 0;
         if (notify_pos + 1 >= tbl_total) begin
            put_bit(1'b1); put_bit(list_num[1]); put_bit(list_num[0]);
         end else begin
            put_bit(1'b0);
         end
         notify_pos++;
         if (notify_pos >= tbl_total) notify_pos = 0;
         if (tbl_total > 0) begin
            fr = tbl_ref[0]; fd = tbl_desc[0]; fl = tbl_len[0];
            put_bit(1'b1);
            for (int k = 39; k >= 4; k--) put_bit(fr[k]);
            if (fl != 0) begin
               put_bit(1'b1);
               for (int k = 23; k >= 24 - 8 * int'(fl); k--) put_bit(fd[k]);
               put_bit(1'b0);
            end else begin
               put_bit(1'b0);
            end
            for (int i = 0; i + 1 < tbl_total; i++) begin
               tbl_ref[i] = tbl_ref[i+1]; tbl_desc[i] = tbl_desc[i+1];
               tbl_len[i] = tbl_len[i+1];
            end
            tbl_ref[tbl_total-1] = fr; tbl_desc[tbl_total-1] = fd;
            tbl_len[tbl_total-1] = fl;
         end
         put_bit(1'b0);
         for (int i = 0; i < BlockBytes; i++) begin
            res.status = ST_OK; res.byte_val = blk[i]; res.last = (i == BlockBytes - 1);
            awaited_q.push_back(res);
         end
         return;
      end
      if (f == FUNC_ADD) begin
         if (find_entry(r) >= 0) st = ST_DUP;
         else if (tbl_total >= MaxEntries) st = ST_FULL;
         else begin
            for (int i = tbl_total; i > 0; i--) begin
               tbl_ref[i] = tbl_ref[i-1]; tbl_desc[i] = tbl_desc[i-1];
               tbl_len[i] = tbl_len[i-1];
            end
            tbl_ref[0] = r; tbl_desc[0] = d; tbl_len[0] = l;
            tbl_total++; notify_pos = 0; list_num++;
         end
      end else if (f == FUNC_DEL) begin
         idx = find_entry(r);
         if (idx < 0) st = ST_NOTFND;
         else begin
            for (int i = idx; i + 1 < tbl_total; i++) begin
               tbl_ref[i] = tbl_ref[i+1]; tbl_desc[i] = tbl_desc[i+1];
               tbl_len[i] = tbl_len[i+1];
            end
            tbl_total--; notify_pos = 0;
         end
      end else begin
         tbl_total = 0; notify_pos = 0;
      end
      res.status = st; res.byte_val = 8'h00; res.last = 1'b1;
      awaited_q.push_back(res);
   endtask

   initial begin
      fail_count = 0; rsp_seen = 0;
      tbl_total = 0; notify_pos = 0; list_num = 2'd0;
   end

   always @(posedge clock) begin
      sched_result e;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_item(req_func, req_group_ref, req_chan_desc, req_chan_desc_len);
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (awaited_q.size() == 0) begin
               $error("unexpected result transfer: status %0d byte %h", rsp_status,
                      rsp_block_byte);
               fail_count++;
            end else begin
               e = awaited_q.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_block_byte !== e.byte_val) begin
                  $error("block_byte: expected %h, got %h", e.byte_val, rsp_block_byte);
                  fail_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

FILE: tb/sv/tb_group_call_notification_scheduler.sv
// Testbench top: drives random and directed table operations and generates.
module tb_group_call_notification_scheduler;
   import gcns_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_func = FUNC_RST;
   logic [RefW-1:0]   req_group_ref = '0;
   logic [DescW-1:0]  req_chan_desc = '0;
   logic [1:0]        req_chan_desc_len = 2'd0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [7:0]        rsp_block_byte;
   logic              rsp_last;
   int                fail_count, pending_count, rsp_seen;
   int                idle_pct = 28;   // shared by both sides; zeroed for a calm stretch
   int                n_items = 0;
   logic [RefW-1:0]   ref_pool[6];     // small pool so duplicates and hits are common

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   group_call_notification_scheduler dut (.*);

   gcns_checker u_checker (.*);

   // receiver stall, random but with the same idle share as the sender
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < idle_pct);

   // one transfer: hold payload until accepted; valid drops only when idling
   task automatic send_item(logic [1:0] f, logic [RefW-1:0] r,
                            logic [DescW-1:0] d, logic [1:0] l);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f; req_group_ref <= r; req_chan_desc <= d; req_chan_desc_len <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_items++;
   endtask

   initial begin
      // generous bound: 424 items, each up to 23 stalled results plus gaps
      #(12 * 1000000);
      $display("group_call_notification_scheduler test failed");
      $finish;
   end

   initial begin
      int          sel, waited;
      logic [1:0]  f;
      for (int i = 0; i < 6; i++) ref_pool[i] = {$urandom(), 8'($urandom())};
      ref_pool[0] = '1;
      ref_pool[1] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-table generate and delete, field extremes,
      // fill to full, refused add, duplicates, every description length
      send_item(FUNC_GEN, '0, '0, 2'd0);
      send_item(FUNC_DEL, '1, '0, 2'd0);
      send_item(FUNC_ADD, '1, '1, 2'd3);
      send_item(FUNC_ADD, '1, '0, 2'd1);
      send_item(FUNC_ADD, '0, 24'hA5C3E1, 2'd1);
      send_item(FUNC_ADD, 40'h5A5A5A5A5A, 24'h123456, 2'd2);
      send_item(FUNC_ADD, 40'hA5A5A5A5A5, '1, 2'd0);
      for (int i = 0; i < 5; i++)
         send_item(FUNC_ADD, {$urandom(), 8'(i)}, 24'($urandom()), 2'(i));
      send_item(FUNC_ADD, 40'h0123456789, '0, 2'd3);
      send_item(FUNC_GEN, '0, '0, 2'd0);
      send_item(FUNC_GEN, '1, '1, 2'd3);
      send_item(FUNC_GEN, '0, '0, 2'd0);
      send_item(FUNC_DEL, 40'h5A5A5A5A5A, '0, 2'd0);
      send_item(FUNC_GEN, '0, '0, 2'd0);
      send_item(FUNC_DEL, '0, '0, 2'd0);
      send_item(FUNC_RST, '0, '0, 2'd0);
      send_item(FUNC_GEN, '0, '0, 2'd0);
      send_item(FUNC_ADD, 40'h0123456789, 24'hFFFF00, 2'd2);
      send_item(FUNC_GEN, '0, '0, 2'd0);
      send_item(FUNC_GEN, '0, '0, 2'd0);

      // random: mostly adds/generates against a small reference pool,
      // with the middle stretch free of idling on both sides
      for (int i = 0; i < 400; i++) begin
         idle_pct = (i >= 150 && i < 220) ? 0 : 28;
         sel = $urandom_range(99);
         f = (sel < 35) ? FUNC_ADD : (sel < 55) ? FUNC_DEL : (sel < 60) ? FUNC_RST
                                   : FUNC_GEN;
         send_item(f,
                   ($urandom_range(3) == 0) ? {$urandom(), 8'($urandom())}
                                            : ref_pool[$urandom_range(5)],
                   24'($urandom()), 2'($urandom_range(3)));
      end
      req_valid <= 1'b0;
      idle_pct = 28;

      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      $display("Covered %0d items (adds, deletes, resets, generates) and %0d result transfers,",
               n_items, rsp_seen);
      $display("including a full table, refused adds and empty-table blocks.");
      if (fail_count == 0 && pending_count == 0)
         $display("group_call_notification_scheduler test passed");
      else
         $display("group_call_notification_scheduler test failed");
      $finish;
   end
endmodule

FILE: group_call_notification_scheduler.f
design/gcns_pkg.sv
design/group_call_notification_scheduler.sv
tb/sv/gcns_checker.sv
tb/sv/tb_group_call_notification_scheduler.sv
